>>> rtl/core/bdar_pkg.sv
// Shared types and constants for the button debounce and auto-repeat block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdar_pkg;

   localparam int BUTTON_COUNT_DEF = 6;
   localparam int TICK_WIDTH_DEF   = 32;
   localparam int MAX_EVENTS       = 6;
   localparam int CFG_W            = 16;
   localparam int BUTTON_W         = 3;
   localparam int CSR_INDEX_W      = 2;
   localparam int EVENT_CNT_W      = $clog2(MAX_EVENTS + 1);

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd30;
   localparam logic [CFG_W-1:0] FIRST_REPEAT_RESET = 16'd400;
   localparam logic [CFG_W-1:0] REPEAT_RESET       = 16'd400;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   localparam logic KIND_SHORT  = 1'b0;
   localparam logic KIND_REPEAT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_FIRST_REPEAT = 2'd1,
      CSR_REPEAT       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] first_repeat_ticks;
      logic [CFG_W-1:0] repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic kind;
   } ev_type;

endpackage

`default_nettype wire

>>> rtl/core/bdar_lane.sv
// One button lane: debounce deadline, qualified level, hold and repeat timing.
// Depends on bdar_pkg for the configuration and event structs.
`default_nettype none

module bdar_lane #(
   parameter int TICK_WIDTH = bdar_pkg::TICK_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  edge_hit,
   input  logic                  scan,
   input  logic [TICK_WIDTH-1:0] now,
   input  logic                  level,
   input  bdar_pkg::cfg_type     cfg,
   output bdar_pkg::ev_type      ev
);
   import bdar_pkg::*;

   localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

   logic                  pending_ff, pending_in;
   logic                  stable_ff, stable_in;
   logic                  held_ff, held_in;
   logic                  repeated_ff, repeated_in;
   logic [TICK_WIDTH-1:0] deadline_ff, deadline_in;
   logic [TICK_WIDTH-1:0] last_rep_ff, last_rep_in;

   logic [TICK_WIDTH-1:0] since_deadline;
   logic [TICK_WIDTH-1:0] elapsed;
   logic [CMP_W-1:0]      deadline_sum;
   logic [CFG_W-1:0]      due;
   logic                  fire, press, release_q, short_ev, rep_ev;
   logic                  held_after, repeated_after;

   always_comb begin
      since_deadline = now - deadline_ff;
      deadline_sum   = CMP_W'(now) + CMP_W'(cfg.debounce_ticks);

      // resample once the deadline is reached, wrap-safe
      fire      = scan && pending_ff && !since_deadline[TICK_WIDTH-1];
      press     = fire && (level != stable_ff) && !level && !held_ff;
      release_q = fire && (level != stable_ff) && level && held_ff;
      short_ev  = release_q && !repeated_ff;

      held_after     = press ? 1'b1 : (release_q ? 1'b0 : held_ff);
      repeated_after = (press || release_q) ? 1'b0 : repeated_ff;

      elapsed = now - last_rep_ff;
      due     = repeated_after ? cfg.repeat_ticks : cfg.first_repeat_ticks;
      rep_ev  = scan && held_after && !press && (CMP_W'(elapsed) >= CMP_W'(due));

      pending_in  = edge_hit ? 1'b1 : (fire ? 1'b0 : pending_ff);
      deadline_in = edge_hit ? deadline_sum[TICK_WIDTH-1:0] : deadline_ff;
      stable_in   = fire ? level : stable_ff;
      held_in     = held_after;
      repeated_in = rep_ev ? 1'b1 : repeated_after;
      last_rep_in = (press || rep_ev) ? now : last_rep_ff;

      ev.valid = short_ev || rep_ev;
      ev.kind  = rep_ev ? KIND_REPEAT : KIND_SHORT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         stable_ff   <= 1'b1;
         held_ff     <= 1'b0;
         repeated_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         stable_ff   <= stable_in;
         held_ff     <= held_in;
         repeated_ff <= repeated_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      last_rep_ff <= last_rep_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/bdar_merge.sv
// Merge stage: collects the lane events of one scan and sends them out in
// button order through an output register, one beat per cycle while not stalled.
// Depends on bdar_pkg for the event struct and the event limit.
`default_nettype none

module bdar_merge #(
   parameter int BUTTON_COUNT = bdar_pkg::BUTTON_COUNT_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  bdar_pkg::ev_type [BUTTON_COUNT-1:0]      lane_ev,
   input  logic                                     rsp_stall,
   output logic                                     rsp_valid,
   output logic [bdar_pkg::BUTTON_W-1:0]            rsp_event_button,
   output logic                                     rsp_kind,
   output logic                                     rsp_last,
   output logic                                     busy
);
   import bdar_pkg::*;

   logic [BUTTON_COUNT-1:0] mask_ff, mask_in;
   logic [BUTTON_COUNT-1:0] kind_ff, kind_in;
   logic [EVENT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BUTTON_W-1:0]     button_ff, button_in;
   logic                    kind_out_ff, kind_out_in;
   logic                    last_ff, last_in;

   logic [BUTTON_COUNT-1:0] lowest;
   logic [BUTTON_COUNT-1:0] rest;
   logic [BUTTON_W-1:0]     idx;
   logic                    is_last;

   always_comb begin
      lowest = mask_ff & (~mask_ff + BUTTON_COUNT'(1));
      rest   = mask_ff & ~lowest;
      idx    = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (lowest[i]) begin
            idx = idx | BUTTON_W'(i);
         end
      end
      // cut the scan short once the event limit is reached
      is_last = (rest == '0) || (cnt_ff == EVENT_CNT_W'(MAX_EVENTS - 1));

      mask_in      = mask_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      button_in    = button_ff;
      kind_out_in  = kind_out_ff;
      last_in      = last_ff;

      if (load) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            mask_in[i] = lane_ev[i].valid;
            kind_in[i] = lane_ev[i].kind;
         end
         cnt_in = '0;
      end else if ((mask_ff != '0) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         button_in    = idx;
         kind_out_in  = |(lowest & kind_ff);
         last_in      = is_last;
         mask_in      = is_last ? '0 : rest;
         cnt_in       = cnt_ff + EVENT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      button_ff   <= button_in;
      kind_out_ff <= kind_out_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = button_ff;
   assign rsp_kind         = kind_out_ff;
   assign rsp_last         = last_ff;
   assign busy             = (mask_ff != '0) || rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_auto_repeat.sv
// Button debounce and auto-repeat qualifier, top level: configuration
// registers, one lane per button, and the merge stage. Depends on bdar_pkg.
`default_nettype none

// An edge item (op 0) arms the debounce deadline of one button. A scan item
// (op 1) is evaluated by all button lanes in parallel in the cycle it is
// accepted; the merge stage then sends its events in button order, one beat
// per cycle while the output is not stalled, at most MAX_EVENTS per scan, the
// final one flagged by rsp_last. req_stall stays high until the last beat has
// left the output register, so no new item is taken before a scan is through.
// Timing compares are modulo 2^TICK_WIDTH. Configuration writes are taken at
// any time (csr_ready is always high) and should be made while no item is in
// flight.

module button_debounce_auto_repeat #(
   parameter int BUTTON_COUNT = bdar_pkg::BUTTON_COUNT_DEF,
   parameter int TICK_WIDTH   = bdar_pkg::TICK_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [bdar_pkg::BUTTON_W-1:0]      req_button,
   input  logic [TICK_WIDTH-1:0]              req_now,
   input  logic [BUTTON_COUNT-1:0]            req_levels,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdar_pkg::BUTTON_W-1:0]      rsp_event_button,
   output logic                               rsp_kind,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdar_pkg::CFG_W-1:0]         csr_data
);
   import bdar_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    busy;
   logic    accept, scan;
   ev_type [BUTTON_COUNT-1:0] lane_ev;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:     cfg_in.debounce_ticks     = csr_data;
            CSR_FIRST_REPEAT: cfg_in.first_repeat_ticks = csr_data;
            CSR_REPEAT:       cfg_in.repeat_ticks       = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= DEBOUNCE_RESET;
         cfg_ff.first_repeat_ticks <= FIRST_REPEAT_RESET;
         cfg_ff.repeat_ticks       <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold off new beats until the current scan has drained
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign scan      = accept && (req_op == OP_SCAN);

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic edge_hit;
      assign edge_hit = accept && (req_op == OP_EDGE) && (32'(req_button) == 32'(i));

      bdar_lane #(
         .TICK_WIDTH(TICK_WIDTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .edge_hit (edge_hit),
         .scan     (scan),
         .now      (req_now),
         .level    (req_levels[i]),
         .cfg      (cfg_ff),
         .ev       (lane_ev[i])
      );
   end

   bdar_merge #(
      .BUTTON_COUNT(BUTTON_COUNT)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (scan),
      .lane_ev          (lane_ev),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_event_button (rsp_event_button),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .busy             (busy)
   );

endmodule

`default_nettype wire

>>> rtl/core/bdar_checker.sv
// Port-level checks for button_debounce_auto_repeat, bound to the top level.
// Depends on bdar_pkg for the button field width and op codes.
`default_nettype none

module bdar_checker #(
   parameter int BUTTON_COUNT = bdar_pkg::BUTTON_COUNT_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_op,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bdar_pkg::BUTTON_W-1:0] rsp_event_button,
   input logic                          rsp_kind,
   input logic                          rsp_last
);
   import bdar_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_button)
         && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // no new item while a result beat is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   // an edge beat never produces a result
   a_edge_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_EDGE) |=> !rsp_valid)
      else $error("result after edge beat");

   // events only name existing buttons (checked only when BUTTON_COUNT is at most 8)
   a_button_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_event_button) < 32'(BUTTON_COUNT)) || (BUTTON_COUNT > 8))
      else $error("event for unknown button");

endmodule

bind button_debounce_auto_repeat bdar_checker #(
   .BUTTON_COUNT(BUTTON_COUNT)
) u_bdar_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_button (rsp_event_button),
   .rsp_kind         (rsp_kind),
   .rsp_last         (rsp_last)
);

`default_nettype wire
